[hdl/bmhq_pkg.sv]
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants for the binary max-heap priority queue:
// field widths, operation and status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bmhq_pkg;

  // fixed field widths
  localparam int KEY_W     = 32;
  localparam int STATUS_W  = 2;
  localparam int ENTRIES_W = 11;

  typedef logic signed [KEY_W-1:0] key_t;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_ROOT,
    S_POP_LAST,
    S_POP_GOT,
    S_DN_LEFT,
    S_DN_RIGHT,
    S_DN_CMP,
    S_FINISH
  } state_t;

  // read address select
  typedef enum logic [2:0] {
    RD_NONE,
    RD_ROOT,
    RD_LAST,
    RD_PARENT,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_t;

  // write source select
  typedef enum logic [1:0] {
    WR_NONE,
    WR_KEY,
    WR_PARENT,
    WR_CHILD
  } wr_sel_t;

  // controller to datapath
  typedef struct packed {
    logic    start;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    ld_removed;
    logic    ld_last;
    logic    ld_left;
    logic    out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_pop;
    logic reject;
    logic at_root;
    logic count_zero;
    logic left_in;
    logic up_move;
    logic down_move;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

[hdl/bmhq_intf.sv]
// ----------------------------------------------------------------------------
// bmhq_intf
// Valid/ready channels of the heap queue: request items (push or pop) and
// result items (removed key, status, count after the operation).
// ----------------------------------------------------------------------------
`default_nettype none

interface bmhq_req_if import bmhq_pkg::*; ();
  logic valid;
  logic ready;
  logic operation;
  key_t key_in;

  modport source (output valid, output operation, output key_in, input ready);
  modport sink (input valid, input operation, input key_in, output ready);
endinterface

interface bmhq_rsp_if import bmhq_pkg::*; ();
  logic                valid;
  logic                ready;
  key_t                removed_key;
  logic [STATUS_W-1:0] status;
  logic [ENTRIES_W-1:0] entries_after;

  modport source (output valid, output removed_key, output status,
                  output entries_after, input ready);
  modport sink (input valid, input removed_key, input status,
                input entries_after, output ready);
endinterface

`default_nettype wire

[hdl/binary_max_heap_queue.sv]
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// Binary max-heap priority queue of signed 32-bit keys: push a key or pop
// the largest, one result item per request item.
// ----------------------------------------------------------------------------
//  channel   dir  handshake    payload
//  request   in   valid/ready  operation, key_in
//  result    out  valid/ready  removed_key, status, entries_after
//
// One request item at a time: a new request is accepted only after the
// previous result has been loaded into the output register. A push walks
// up one level per parent read and compare until it reaches the root or
// stops below. A pop reads the root, then the last entry, and finishes
// there when that empties the heap; otherwise it walks down, each level
// reading the left and then the right child through the single registered
// RAM read port and then comparing. A rejected push or pop goes straight
// to its result. Reset empties the heap. A result waiting in the output
// register does not block the next request; the following result waits
// until that register is taken.
`default_nettype none

module binary_max_heap_queue import bmhq_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input wire logic  clk,
  input wire logic  rst,
  bmhq_req_if.sink  request,
  bmhq_rsp_if.source result
);

  cmd_t  cmd;
  stat_t st;
  logic  ready;

  assign request.ready = ready;

  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .st        (st),
    .ready     (ready),
    .cmd       (cmd)
  );

  bmhq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .st                (st),
    .req_operation     (request.operation),
    .req_key_in        (request.key_in),
    .rsp_valid         (result.valid),
    .rsp_ready         (result.ready),
    .rsp_removed_key   (result.removed_key),
    .rsp_status        (result.status),
    .rsp_entries_after (result.entries_after)
  );

endmodule

`default_nettype wire

[hdl/bmhq_ram.sv]
// ----------------------------------------------------------------------------
// bmhq_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hdl/bmhq_ctrl.sv]
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Controller of the heap queue: sequences the sift-up walk of a push and
// the root read, last-entry move and sift-down walk of a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_ctrl import bmhq_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  req_valid,
  input  wire stat_t st,
  output logic       ready,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (st.reject) begin
            state_next = S_FINISH;
          end else if (st.req_pop) begin
            state_next = S_POP_ROOT;
          end else begin
            state_next = S_UP_RD;
          end
        end
      end
      S_UP_RD:    state_next = st.at_root ? S_FINISH : S_UP_CMP;
      S_UP_CMP:   state_next = st.up_move ? S_UP_RD : S_FINISH;
      S_POP_ROOT: state_next = S_POP_LAST;
      S_POP_LAST: state_next = S_POP_GOT;
      S_POP_GOT:  state_next = st.count_zero ? S_FINISH : S_DN_LEFT;
      S_DN_LEFT:  state_next = st.left_in ? S_DN_RIGHT : S_FINISH;
      S_DN_RIGHT: state_next = S_DN_CMP;
      S_DN_CMP:   state_next = st.down_move ? S_DN_LEFT : S_FINISH;
      S_FINISH:   state_next = st.out_free ? S_IDLE : S_FINISH;
      default:    state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ready          = 1'b0;
    cmd            = '0;
    cmd.rd_sel     = RD_NONE;
    cmd.wr_sel     = WR_NONE;
    case (state)
      S_IDLE: begin
        ready     = 1'b1;
        cmd.start = req_valid;
      end
      S_UP_RD: begin
        if (st.at_root) begin
          cmd.wr_sel = WR_KEY;
        end else begin
          cmd.rd_sel = RD_PARENT;
        end
      end
      S_UP_CMP: begin
        cmd.wr_sel = st.up_move ? WR_PARENT : WR_KEY;
      end
      S_POP_ROOT: begin
        cmd.rd_sel = RD_ROOT;
      end
      S_POP_LAST: begin
        cmd.ld_removed = 1'b1;
        cmd.rd_sel     = RD_LAST;
      end
      S_POP_GOT: begin
        cmd.ld_last = !st.count_zero;
      end
      S_DN_LEFT: begin
        if (st.left_in) begin
          cmd.rd_sel = RD_LEFT;
        end else begin
          cmd.wr_sel = WR_KEY;
        end
      end
      S_DN_RIGHT: begin
        cmd.ld_left = 1'b1;
        cmd.rd_sel  = RD_RIGHT;
      end
      S_DN_CMP: begin
        cmd.wr_sel = st.down_move ? WR_CHILD : WR_KEY;
      end
      S_FINISH: begin
        cmd.out_load = st.out_free;
      end
      default: begin
        ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/bmhq_dp.sv]
// ----------------------------------------------------------------------------
// bmhq_dp
// Datapath of the heap queue: key store, entry count, walk position, the
// key being moved, child compare and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_dp import bmhq_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cmd_t                 cmd,
  output stat_t                     st,
  input  wire logic                 req_operation,
  input  wire key_t                 req_key_in,
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output key_t                      rsp_removed_key,
  output logic [STATUS_W-1:0]       rsp_status,
  output logic [ENTRIES_W-1:0]      rsp_entries_after
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;

  logic [CW-1:0]  count;
  logic [AW-1:0]  pos;
  key_t           hold_key;
  key_t           left_key;
  key_t           removed;
  status_t        res_status;

  logic [KEY_W-1:0] rd_raw;
  key_t             rd_key;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  key_t             wr_data;

  logic [AW-1:0]  pos_m1;
  logic [AW-1:0]  parent;
  logic [IW-1:0]  left_w;
  logic [IW-1:0]  right_w;
  logic [IW-1:0]  count_w;
  logic           right_in;
  logic           full;
  logic           empty;
  key_t           best_key;
  logic [AW-1:0]  best_idx;
  logic           best_move;

  // index arithmetic
  assign rd_key  = rd_raw;
  assign pos_m1  = pos - AW'(1);
  assign parent  = AW'(pos_m1 >> 1);
  assign left_w  = {1'b0, pos, 1'b1};
  assign right_w = left_w + IW'(1);
  assign count_w = IW'(count);
  assign right_in = right_w < count_w;
  assign full    = count == CW'(CAPACITY);
  assign empty   = count == '0;

  // pick the larger child; left wins ties, the moved key wins ties
  always_comb begin
    best_key  = hold_key;
    best_idx  = pos;
    best_move = 1'b0;
    if (hold_key < left_key) begin
      best_key  = left_key;
      best_idx  = left_w[AW-1:0];
      best_move = 1'b1;
    end
    if (right_in && (best_key < rd_key)) begin
      best_key  = rd_key;
      best_idx  = right_w[AW-1:0];
      best_move = 1'b1;
    end
  end

  // status to controller
  always_comb begin
    st.req_pop    = req_operation == OP_POP;
    st.reject     = (req_operation == OP_POP) ? empty : full;
    st.at_root    = pos == '0;
    st.count_zero = empty;
    st.left_in    = left_w < count_w;
    st.up_move    = rd_key < hold_key;
    st.down_move  = best_move;
    st.out_free   = !rsp_valid || rsp_ready;
  end

  // read address mux
  always_comb begin
    rd_en   = cmd.rd_sel != RD_NONE;
    rd_addr = '0;
    case (cmd.rd_sel)
      RD_ROOT:   rd_addr = '0;
      RD_LAST:   rd_addr = count[AW-1:0];
      RD_PARENT: rd_addr = parent;
      RD_LEFT:   rd_addr = left_w[AW-1:0];
      RD_RIGHT:  rd_addr = right_w[AW-1:0];
      default:   rd_addr = '0;
    endcase
  end

  // write data mux, always at the walk position
  always_comb begin
    wr_en   = cmd.wr_sel != WR_NONE;
    wr_data = hold_key;
    case (cmd.wr_sel)
      WR_KEY:    wr_data = hold_key;
      WR_PARENT: wr_data = rd_key;
      WR_CHILD:  wr_data = best_key;
      default:   wr_data = hold_key;
    endcase
  end

  bmhq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pos),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.start && !st.reject) begin
      if (req_operation == OP_POP) begin
        count <= count - CW'(1);
      end else begin
        count <= count + CW'(1);
      end
    end
  end

  // walk registers and pending result
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hold_key <= req_key_in;
      pos      <= count[AW-1:0];
      removed  <= '0;
      if (st.reject) begin
        res_status <= (req_operation == OP_POP) ? STAT_EMPTY : STAT_FULL;
      end else begin
        res_status <= STAT_DONE;
      end
    end
    if (cmd.ld_removed) begin
      removed <= rd_key;
    end
    if (cmd.ld_last) begin
      hold_key <= rd_key;
      pos      <= '0;
    end
    if (cmd.ld_left) begin
      left_key <= rd_key;
    end
    case (cmd.wr_sel)
      WR_PARENT: pos <= parent;
      WR_CHILD:  pos <= best_idx;
      default:   ;
    endcase
  end

  // result output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_removed_key   <= removed;
      rsp_status        <= res_status;
      rsp_entries_after <= ENTRIES_W'(count);
    end
  end

endmodule

`default_nettype wire
